/* hdl/lnb_pkg.sv */
// lnb_pkg: shared types and constants for the node id bucket
`default_nettype none
package lnb_pkg;
  localparam int MaxEntries = 16;
  localparam int InfoBits   = 48;
  localparam int IdxW       = $clog2(MaxEntries);
  localparam int CntW       = $clog2(MaxEntries + 1);
  localparam int IdW        = 160;

  localparam logic [2:0] KIND_LOOKUP = 3'd0;
  localparam logic [2:0] KIND_OLDEST = 3'd1;
  localparam logic [2:0] KIND_STORE  = 3'd2;
  localparam logic [2:0] KIND_REMOVE = 3'd3;
  localparam logic [2:0] KIND_LIST   = 3'd4;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_ABSENT = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;

  typedef enum logic [2:0] {
    OP_CLEAR  = 3'd0,
    OP_APPEND = 3'd1,
    OP_SHIFT  = 3'd2,
    OP_TOBACK = 3'd3
  } dp_op_t;

  // controller to datapath
  typedef struct packed {
    logic       load;      // capture input item, run search
    dp_op_t     op;        // list update applied when upd is high
    logic       upd;
    logic       rd;        // read slot rd_idx into the output register
    logic [IdxW-1:0] rd_idx;
    logic       zero_out;  // unused; the datapath loads a zero payload whenever rd is low
    logic [1:0] status;
    logic       last;
    logic       out_load;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic            hit;
    logic [IdxW-1:0] hit_idx;
    logic [CntW-1:0] count;
  } dp_sts_t;
endpackage
`default_nettype wire

/* hdl/lru_node_id_bucket_unit.sv */
// lru_node_id_bucket_unit: top level of the least-recently-seen node id bucket
//  channel | dir | fields
//  s_axis  | in  | tuser kind; tdata id_low, id_mid, id_high, node_info, max_count
//  m_axis  | out | tuser status; tdata out_id_low/mid/high, out_info; tlast last
//  apb     | in  | capacity at address 0
// one item: accept, id search, execute, output
// after the search a list takes each entry in turn: slot read, then output
// each output cycle stretches while m_axis_tready is low; input waits until idle
// synchronous reset empties the bucket and sets capacity to 16
`default_nettype none
module lru_node_id_bucket_unit import lnb_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [215:0] s_axis_tdata,  // id_low, id_mid, id_high, node_info, max_count, pad
  input  wire logic [2:0]   s_axis_tuser,  // kind
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [207:0]      m_axis_tdata,  // out_id_low, out_id_mid, out_id_high, out_info
  output logic [1:0]        m_axis_tuser,  // status
  output logic              m_axis_tlast,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [1:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  dp_cmd_t cmd;
  dp_sts_t sts;
  logic [4:0] capacity;
  logic [IdW-1:0] out_id;
  logic [InfoBits-1:0] out_info;

  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? {27'd0, capacity} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) capacity <= 5'd16;
    else if (psel && penable && pwrite && paddr == 2'd0) capacity <= pwdata[4:0];
  end

  lnb_ctrl u_ctrl (
    .clk, .rst,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_kind(s_axis_tuser), .in_max(s_axis_tdata[212:208]),
    .capacity,
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .sts, .cmd
  );

  lnb_datapath u_dp (
    .clk, .rst, .cmd,
    .in_id(s_axis_tdata[159:0]), .in_info(s_axis_tdata[207:160]),
    .sts,
    .out_status(m_axis_tuser), .out_id, .out_info, .out_last(m_axis_tlast)
  );

  assign m_axis_tdata = {out_info, out_id};
endmodule
`default_nettype wire

/* hdl/lnb_datapath.sv */
// lnb_datapath: entry store, parallel id compare and output register
`default_nettype none
module lnb_datapath import lnb_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire dp_cmd_t             cmd,
  input  wire logic [IdW-1:0]      in_id,
  input  wire logic [InfoBits-1:0] in_info,
  output dp_sts_t                  sts,
  output logic [1:0]               out_status,
  output logic [IdW-1:0]           out_id,
  output logic [InfoBits-1:0]      out_info,
  output logic                     out_last
);
  logic [IdW-1:0]      ids   [MaxEntries];
  logic [InfoBits-1:0] infos [MaxEntries];
  logic [CntW-1:0]     count;
  logic [IdW-1:0]      key;
  logic [InfoBits-1:0] key_info;
  logic [MaxEntries-1:0] match;
  logic                  hit;
  logic [IdxW-1:0]       hit_idx;
  logic [IdxW-1:0]       tail;

  // parallel compare against live slots
  always_comb begin
    match = '0;
    for (int i = 0; i < MaxEntries; i++) begin
      match[i] = (ids[i] == key) && (CntW'(i) < count);
    end
  end

  // first matching slot, registered for the controller
  always_ff @(posedge clk) begin
    hit <= 1'b0;
    hit_idx <= '0;
    for (int i = MaxEntries - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit <= 1'b1;
        hit_idx <= IdxW'(i);
      end
    end
  end

  assign tail = IdxW'(count - CntW'(1));
  assign sts = '{hit: hit, hit_idx: hit_idx, count: count};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key <= in_id;
      key_info <= in_info;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.upd) begin
      unique case (cmd.op)
        OP_APPEND: count <= count + CntW'(1);
        OP_SHIFT:  count <= count - CntW'(1);
        default:   count <= count;
      endcase
    end
  end

  // slot moves: gap closing, append and move to back
  always_ff @(posedge clk) begin
    if (cmd.upd) begin
      unique case (cmd.op)
        OP_APPEND: begin
          ids[count[IdxW-1:0]] <= key;
          infos[count[IdxW-1:0]] <= key_info;
        end
        OP_SHIFT, OP_TOBACK: begin
          for (int i = 0; i < MaxEntries - 1; i++) begin
            if (IdxW'(i) >= hit_idx && IdxW'(i) < tail) begin
              ids[i] <= ids[i+1];
              infos[i] <= infos[i+1];
            end
          end
          if (cmd.op == OP_TOBACK) begin
            ids[tail] <= ids[hit_idx];
            infos[tail] <= infos[hit_idx];
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status <= cmd.status;
      out_last <= cmd.last;
      if (cmd.rd) begin
        out_id <= ids[cmd.rd_idx];
        out_info <= infos[cmd.rd_idx];
      end else begin
        out_id <= '0;
        out_info <= '0;
      end
    end
  end
endmodule
`default_nettype wire

/* hdl/lnb_ctrl.sv */
// lnb_ctrl: operation sequencer for the node id bucket
`default_nettype none
module lnb_ctrl import lnb_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [2:0] in_kind,
  input  wire logic [4:0] in_max,
  input  wire logic [4:0] capacity,
  output logic            out_valid,
  input  wire logic       out_ready,
  input  wire dp_sts_t    sts,
  output dp_cmd_t         cmd
);
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SRCH = 5'b00010,
    S_EXEC = 5'b00100,
    S_LIST = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t state, state_next;
  logic [2:0]      kind;
  logic [CntW-1:0] remain, remain_next;
  logic [CntW-1:0] list_n;
  logic [4:0]      eff_cap;
  logic            more, more_next;
  // entries this list will emit in all
  logic [CntW-1:0] total;

  assign eff_cap = (capacity == 5'd0) ? 5'd1 :
                   (capacity > 5'(MaxEntries)) ? 5'(MaxEntries) : capacity;
  assign list_n = (5'(sts.count) < in_max) ? sts.count : CntW'(in_max);
  assign in_ready = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      kind <= KIND_LOOKUP;
      remain <= '0;
      more <= 1'b0;
    end else begin
      state <= state_next;
      remain <= remain_next;
      more <= more_next;
      if (in_valid && in_ready) kind <= in_kind;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) total <= list_n;
  end

  always_comb begin
    state_next = state;
    remain_next = remain;
    more_next = more;
    cmd = '0;
    cmd.op = OP_CLEAR;
    unique case (state)
      S_IDLE: begin
        cmd.load = in_valid;
        if (in_valid) begin
          remain_next = list_n;
          state_next = S_SRCH;
        end
      end
      // compare result is registered at the end of this cycle
      S_SRCH: begin
        state_next = S_EXEC;
      end
      S_EXEC: begin
        cmd.out_load = 1'b1;
        cmd.last = 1'b1;
        state_next = S_OUT;
        more_next = 1'b0;
        case (kind)
          KIND_LOOKUP: begin
            cmd.status = sts.hit ? ST_OK : ST_ABSENT;
            cmd.rd = sts.hit;
            cmd.rd_idx = sts.hit_idx;
          end
          KIND_OLDEST: begin
            cmd.status = (sts.count == '0) ? ST_ABSENT : ST_OK;
            cmd.rd = (sts.count != '0);
          end
          KIND_STORE: begin
            cmd.status = ST_OK;
            cmd.upd = 1'b1;
            if (sts.hit) cmd.op = OP_TOBACK;
            else if (5'(sts.count) >= eff_cap) begin
              cmd.status = ST_FULL;
              cmd.upd = 1'b0;
            end else cmd.op = OP_APPEND;
          end
          KIND_REMOVE: begin
            cmd.status = sts.hit ? ST_OK : ST_ABSENT;
            cmd.rd = sts.hit;
            cmd.rd_idx = sts.hit_idx;
            cmd.upd = sts.hit;
            cmd.op = OP_SHIFT;
          end
          KIND_LIST: begin
            if (remain == '0) cmd.status = ST_ABSENT;
            else begin
              cmd.out_load = 1'b0;
              state_next = S_LIST;
            end
          end
          default: cmd.status = ST_ABSENT;
        endcase
      end
      S_LIST: begin
        cmd.out_load = 1'b1;
        cmd.status = ST_OK;
        cmd.rd = 1'b1;
        cmd.rd_idx = IdxW'(sts.count - CntW'(1) - (total - remain));
        cmd.last = (remain == CntW'(1));
        more_next = (remain != CntW'(1));
        remain_next = remain - CntW'(1);
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_ready) state_next = more ? S_LIST : S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

/* hdl/lnb_checker.sv */
// lnb_checker: port level checks for the bucket unit
`default_nettype none
module lnb_port_checks import lnb_pkg::*; (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       s_axis_tvalid,
  input wire logic       s_axis_tready,
  input wire logic       m_axis_tvalid,
  input wire logic       m_axis_tready,
  input wire logic       m_axis_tlast,
  input wire logic [1:0] m_axis_tuser
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("result dropped");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready) else $error("input taken while result pending");
  a_stat: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser != ST_OK |-> m_axis_tlast) else $error("error not last");
  a_acc: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready) else $error("second item taken");
endmodule

bind lru_node_id_bucket_unit lnb_port_checks u_chk (
  .clk, .rst, .s_axis_tvalid, .s_axis_tready, .m_axis_tvalid, .m_axis_tready,
  .m_axis_tlast, .m_axis_tuser
);
`default_nettype wire

/* verif/lnb_checker.sv */
// lnb_checker: watches the bucket's stream channels, predicts each result and compares
`timescale 1ns / 1ps
`default_nettype none
module lnb_checker import lnb_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  input  wire logic         s_axis_tready,
  input  wire logic [215:0] s_axis_tdata,
  input  wire logic [2:0]   s_axis_tuser,
  input  wire logic         m_axis_tvalid,
  input  wire logic         m_axis_tready,
  input  wire logic [207:0] m_axis_tdata,
  input  wire logic [1:0]   m_axis_tuser,
  input  wire logic         m_axis_tlast,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [1:0]   paddr,
  input  wire logic [31:0]  pwdata,
  input  wire logic         pready,
  output int                errors,
  output int                pending
);
  typedef struct packed {
    logic [1:0]   status;
    logic [207:0] payload;
    logic         last;
  } bucket_result_t;

  logic [159:0]        node_id [MaxEntries];
  logic [InfoBits-1:0] node_info [MaxEntries];
  int                  node_count;
  logic [4:0]          cap_reg;
  bucket_result_t      expected_results[$];

  function automatic bucket_result_t entry_result(int s, logic lst);
    bucket_result_t r;
    r.status  = ST_OK;
    r.payload = {node_info[s], node_id[s]};
    r.last    = lst;
    return r;
  endfunction

  function automatic bucket_result_t bare_result(logic [1:0] st);
    bucket_result_t r;
    r.status  = st;
    r.payload = '0;
    r.last    = 1'b1;
    return r;
  endfunction

  function automatic int find_node(logic [159:0] id);
    for (int i = 0; i < node_count; i++)
      if (node_id[i] == id) return i;
    return -1;
  endfunction

  task automatic close_gap(int s);
    for (int i = s; i + 1 < node_count; i++) begin
      node_id[i]   = node_id[i+1];
      node_info[i] = node_info[i+1];
    end
  endtask

  task automatic predict_bucket(logic [2:0] kind, logic [215:0] d);
    logic [159:0]        id;
    logic [InfoBits-1:0] info;
    int                  mc, s, n, eff;
    logic [159:0]        tid;
    logic [InfoBits-1:0] tinfo;
    id   = d[159:0];
    info = d[207:160];
    mc   = d[212:208];
    eff  = (cap_reg == 0) ? 1 : (cap_reg > MaxEntries ? MaxEntries : cap_reg);
    case (kind)
      KIND_LOOKUP: begin
        s = find_node(id);
        expected_results.push_back(s >= 0 ? entry_result(s, 1'b1) : bare_result(ST_ABSENT));
      end
      KIND_OLDEST:
        expected_results.push_back(node_count == 0 ? bare_result(ST_ABSENT)
                                                   : entry_result(0, 1'b1));
      KIND_STORE: begin
        s = find_node(id);
        if (s >= 0) begin
          tid = node_id[s];
          tinfo = node_info[s];
          close_gap(s);
          node_id[node_count-1] = tid;
          node_info[node_count-1] = tinfo;
          expected_results.push_back(bare_result(ST_OK));
        end else if (node_count >= eff) begin
          expected_results.push_back(bare_result(ST_FULL));
        end else begin
          node_id[node_count] = id;
          node_info[node_count] = info;
          node_count++;
          expected_results.push_back(bare_result(ST_OK));
        end
      end
      KIND_REMOVE: begin
        s = find_node(id);
        if (s < 0) expected_results.push_back(bare_result(ST_ABSENT));
        else begin
          expected_results.push_back(entry_result(s, 1'b1));
          close_gap(s);
          node_count--;
        end
      end
      KIND_LIST: begin
        n = node_count < mc ? node_count : mc;
        if (n > 16) n = 16;
        if (n == 0) expected_results.push_back(bare_result(ST_ABSENT));
        for (int j = 0; j < n; j++)
          expected_results.push_back(entry_result(node_count - 1 - j, j + 1 == n));
      end
      default: expected_results.push_back(bare_result(ST_ABSENT));
    endcase
  endtask

  always @(posedge clk) begin
    bucket_result_t want;
    if (rst) begin
      node_count = 0;
      cap_reg = 5'd16;
      errors = 0;
      expected_results.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected transfer: status %0d data %h last %0d",
                     m_axis_tuser, m_axis_tdata, m_axis_tlast);
        end else begin
          want = expected_results.pop_front();
          if (want.status !== m_axis_tuser || want.payload !== m_axis_tdata ||
              want.last !== m_axis_tlast) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: exp status %0d data %h last %0d, got %0d %h %0d",
                       want.status, want.payload, want.last,
                       m_axis_tuser, m_axis_tdata, m_axis_tlast);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) predict_bucket(s_axis_tuser, s_axis_tdata);
      if (psel && penable && pwrite && pready && paddr == 2'd0) cap_reg = pwdata[4:0];
    end
    pending = expected_results.size();
  end
endmodule
`default_nettype wire

/* verif/testbench.sv */
// testbench: stimulus, idling and verdict for the node id bucket unit
`timescale 1ns / 1ps
`default_nettype none
module testbench;
  import lnb_pkg::*;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [215:0] s_axis_tdata = '0;
  logic [2:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [207:0] m_axis_tdata;
  logic [1:0]   m_axis_tuser;
  logic         m_axis_tlast;
  logic         psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [1:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;
  int           errors, pending;
  bit           calm = 1'b0;
  bit           hold_off = 1'b0;

  logic [159:0] known_ids[$];

  always #5 clk = ~clk;

  lru_node_id_bucket_unit dut (.*);

  lnb_checker checker_i (.*);

  // receiver: random stall, a calm stretch and a long hold-off
  always @(negedge clk) begin
    if (rst || hold_off) m_axis_tready <= 1'b0;
    else m_axis_tready <= calm || ($urandom_range(99) >= 18);
  end

  task automatic cfg_write(logic [4:0] cap);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= 2'd0; pwdata <= {27'd0, cap};
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic drain;
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  // valid stays up after a transfer until the next item or an idle cycle
  task automatic send_item(logic [2:0] kind, logic [159:0] id, logic [47:0] info,
                           logic [4:0] mc);
    while (!calm && $urandom_range(99) < 18) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {3'd0, mc, info, id};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [159:0] rand_id();
    return {$urandom, $urandom, $urandom, $urandom, $urandom};
  endfunction

  function automatic logic [159:0] pick_id();
    if (known_ids.size() != 0 && $urandom_range(99) < 75)
      return known_ids[$urandom_range(known_ids.size() - 1)];
    return rand_id();
  endfunction

  task automatic random_item();
    logic [159:0] id;
    int           r;
    id = pick_id();
    r = $urandom_range(99);
    if (r < 40) begin
      if (known_ids.size() < 40) known_ids.push_back(id);
      send_item(KIND_STORE, id, 48'({$urandom, $urandom}), 5'($urandom));
    end else if (r < 55)
      send_item(KIND_LOOKUP, id, 48'({$urandom, $urandom}), 5'($urandom));
    else if (r < 70)
      send_item(KIND_REMOVE, id, 48'({$urandom, $urandom}), 5'($urandom));
    else if (r < 78)
      send_item(KIND_OLDEST, id, 48'({$urandom, $urandom}), 5'($urandom));
    else if (r < 95)
      send_item(KIND_LIST, id, 48'({$urandom, $urandom}), 5'($urandom_range(17)));
    else
      send_item(3'($urandom_range(7, 5)), id, 48'({$urandom, $urandom}), 5'($urandom));
  endtask

  initial begin
    logic [159:0] ones;
    ones = '1;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // directed: empty bucket, extremes, unused kinds, full bucket
    send_item(KIND_OLDEST, '0, '0, 5'd0);
    send_item(KIND_LIST, '0, '0, 5'd16);
    send_item(KIND_LOOKUP, ones, '1, 5'd31);
    send_item(KIND_REMOVE, '0, '0, 5'd0);
    send_item(KIND_STORE, '0, '0, 5'd0);
    send_item(KIND_STORE, ones, '1, 5'd31);
    send_item(KIND_STORE, 160'h1234, 48'habcdef, 5'd0);
    send_item(KIND_STORE, '0, 48'h5555, 5'd0);
    send_item(KIND_LOOKUP, ones, '0, 5'd0);
    send_item(KIND_OLDEST, '0, '0, 5'd0);
    send_item(KIND_LIST, '0, '0, 5'd31);
    send_item(KIND_LIST, '0, '0, 5'd0);
    send_item(KIND_LIST, '0, '0, 5'd2);
    send_item(3'd5, ones, '1, 5'd31);
    send_item(3'd7, '0, '0, 5'd0);
    send_item(KIND_REMOVE, ones, '0, 5'd0);
    send_item(KIND_LIST, '0, '0, 5'd16);
    drain();
    cfg_write(5'd2);
    send_item(KIND_STORE, 160'h77, 48'h1, 5'd0);
    send_item(KIND_STORE, 160'h1234, 48'h2, 5'd0);
    send_item(KIND_LIST, '0, '0, 5'd16);
    drain();
    cfg_write(5'd0);
    send_item(KIND_STORE, 160'h99, 48'h3, 5'd0);
    send_item(KIND_REMOVE, '0, '0, 5'd0);
    send_item(KIND_REMOVE, 160'h1234, '0, 5'd0);
    send_item(KIND_STORE, 160'h99, 48'h3, 5'd0);
    drain();
    cfg_write(5'd31);
    for (int i = 0; i < 18; i++)
      send_item(KIND_STORE, rand_id(), 48'({$urandom, $urandom}), 5'd0);
    send_item(KIND_LIST, '0, '0, 5'd31);
    // long hold-off while the sender keeps going
    fork
      begin
        hold_off = 1'b1;
        repeat (300) @(negedge clk);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 8; i++) send_item(KIND_LIST, '0, '0, 5'd16);
    join
    drain();
    // random phases over several capacities
    for (int ph = 0; ph < 6; ph++) begin
      cfg_write(ph == 0 ? 5'd16 : ph == 1 ? 5'd1 : 5'($urandom_range(31)));
      calm = (ph == 3);
      for (int i = 0; i < 50; i++) random_item();
      drain();
    end
    calm = 1'b0;
    if (errors == 0) $display("lru_node_id_bucket_unit regression: pass");
    else $display("lru_node_id_bucket_unit regression: fail");
    $finish;
  end

  initial begin
    #5ms;
    $display("lru_node_id_bucket_unit regression: fail");
    $finish;
  end
endmodule
`default_nettype wire

/* lru_node_id_bucket_unit.f */
hdl/lnb_pkg.sv
hdl/lnb_datapath.sv
hdl/lnb_ctrl.sv
hdl/lru_node_id_bucket_unit.sv
hdl/lnb_checker.sv
verif/lnb_checker.sv
verif/testbench.sv
